### sv/gpid_pkg.sv
// shared constants and types for the gated pid controller
`timescale 1ns / 1ps
package gpid_pkg;

  localparam int DefDataWidth = 32;
  localparam int DefFracBits = 16;
  localparam int DefThrottleThreshold = 1000;

  localparam int FieldWidth = 32;
  localparam int LimitWidth = 31;
  localparam int ThrottleWidth = 16;
  localparam int CfgIndexWidth = 3;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] RegKp = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegKiDt = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegKdEff = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegSetpointScale = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegOutputGain = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegOutputLimit = 3'd5;
  localparam logic [CfgIndexWidth-1:0] RegSumLimit = 3'd6;
  localparam logic [CfgIndexWidth-1:0] RegDerivativeMode = 3'd7;

  localparam logic [LimitWidth-1:0] NoClamp = {LimitWidth{1'b1}};

  // request to the serial multiplier
  typedef struct packed {
    logic start;
  } mul_ctl_t;

  // status back from the serial multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

### sv/gpid_mul.sv
// bit-serial signed fixed-point multiplier with floor shift and saturation
`timescale 1ns / 1ps
module gpid_mul import gpid_pkg::*; #(
  parameter int DATA_WIDTH = DefDataWidth,
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mul_ctl_t                     ctl,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output mul_sts_t                     sts,
  output logic signed [DATA_WIDTH-1:0] p
);

  localparam int PW = 2 * DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam logic signed [PW-1:0] DMax = PW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [PW-1:0] DMin = -DMax - PW'(1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] mcand;
  logic [DATA_WIDTH-1:0] mplier;
  logic [CW-1:0] cnt;
  logic busy;
  logic done;
  logic signed [PW-1:0] acc_next;
  logic signed [PW-1:0] shifted;

  // one multiplier bit per cycle; top bit carries negative weight
  always_comb begin
    acc_next = acc;
    if (mplier[0]) begin
      if (cnt == CW'(DATA_WIDTH - 1)) acc_next = acc - mcand;
      else acc_next = acc + mcand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= '0;
      mcand <= PW'(a);
      mplier <= b;
    end else if (busy) begin
      acc <= acc_next;
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  // arithmetic shift floors; then saturate
  assign shifted = acc >>> FRAC_BITS;
  always_comb begin
    if (shifted > DMax) p = DMax[DATA_WIDTH-1:0];
    else if (shifted < DMin) p = DMin[DATA_WIDTH-1:0];
    else p = shifted[DATA_WIDTH-1:0];
  end

  assign sts.busy = busy;
  assign sts.done = done;

`ifndef SYNTH
  // done is a single pulse that ends a run
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> $past(busy)) else $error("done without run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy) else $error("start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    sts.done |=> !sts.done) else $error("done longer than one cycle");
`endif

endmodule

### sv/gated_pid_controller.sv
// gated pid controller top level: registers, sequencer, shared serial multiplier
//
// channel  dir  handshake        payload
// in       in   in_valid/in_stall    setpoint, process_value, process_rate, throttle
// out      out  out_valid/out_stall  control_value
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// an active item takes five passes of one serial multiplier (six in rate mode),
// plus the clamp and output steps; an idle item skips the multiplier.
// the multiplier, one bit per cycle, sets the rate; one item at a time.
// rst is synchronous and clears registers to their reset values and state to S_IDLE.
// a waiting result sits in the output register; out_stall holds it there.
`timescale 1ns / 1ps
module gated_pid_controller import gpid_pkg::*; #(
  parameter int DATA_WIDTH = DefDataWidth,
  parameter int FRAC_BITS = DefFracBits,
  parameter int THROTTLE_THRESHOLD = DefThrottleThreshold
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FieldWidth-1:0]  setpoint,
  input  logic signed [FieldWidth-1:0]  process_value,
  input  logic signed [FieldWidth-1:0]  process_rate,
  input  logic [ThrottleWidth-1:0]      throttle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FieldWidth-1:0]  control_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CfgIndexWidth-1:0]      cfg_index,
  input  logic [FieldWidth-1:0]         cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int EW = (DW > FieldWidth ? DW : FieldWidth) + 2;
  localparam logic signed [EW-1:0] DMax = EW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [EW-1:0] DMin = -DMax - EW'(1);
  localparam logic signed [EW-1:0] OMax = EW'(33'sh0_7FFF_FFFF);
  localparam logic signed [EW-1:0] OMin = -OMax - EW'(1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_E     = 10'b0000000010,
    S_P     = 10'b0000000100,
    S_I     = 10'b0000001000,
    S_DS    = 10'b0000010000,
    S_D     = 10'b0000100000,
    S_TOT   = 10'b0001000000,
    S_Y     = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [FieldWidth-1:0] kp, ki_dt, kd_eff, setpoint_scale, output_gain;
  logic [LimitWidth-1:0] output_limit, sum_limit;
  logic derivative_mode;

  // item and working registers
  logic signed [DW-1:0] sp, pv, rate;
  logic signed [DW-1:0] error_sum, previous_term;
  logic signed [DW-1:0] e, sum, pt, it, dt;
  logic signed [DW-1:0] total;
  logic signed [FieldWidth-1:0] result;
  logic res_valid;
  logic mul_wait;

  mul_ctl_t mctl;
  mul_sts_t msts;
  logic signed [DW-1:0] ma, mb, mp;

  // saturate a wide value to the data range
  function automatic logic signed [DW-1:0] satd(input logic signed [EW-1:0] v);
    if (v > DMax) return DMax[DW-1:0];
    if (v < DMin) return DMin[DW-1:0];
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sxf(input logic [FieldWidth-1:0] v);
    logic signed [EW-1:0] w;
    w = EW'(signed'(v));
    return satd(w);
  endfunction

  assign cfg_ready = (state == S_IDLE) && !res_valid;
  assign in_stall = (state != S_IDLE) || res_valid;
  assign out_valid = res_valid;
  assign control_value = result;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= '0;
      ki_dt <= '0;
      kd_eff <= '0;
      setpoint_scale <= FieldWidth'(65536);
      output_gain <= FieldWidth'(65536);
      output_limit <= NoClamp;
      sum_limit <= NoClamp;
      derivative_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegKp: kp <= cfg_data;
        RegKiDt: ki_dt <= cfg_data;
        RegKdEff: kd_eff <= cfg_data;
        RegSetpointScale: setpoint_scale <= cfg_data;
        RegOutputGain: output_gain <= cfg_data;
        RegOutputLimit: output_limit <= cfg_data[LimitWidth-1:0];
        RegSumLimit: sum_limit <= cfg_data[LimitWidth-1:0];
        RegDerivativeMode: derivative_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // multiplier operand selection by step
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_E: begin ma = sp; mb = sxf(setpoint_scale); end
      S_P: begin ma = sxf(kp); mb = e; end
      S_I: begin ma = sxf(ki_dt); mb = sum; end
      S_DS: begin
        ma = satd(EW'(sp) - EW'(previous_term));
        mb = sxf(setpoint_scale);
      end
      S_D: begin
        ma = sxf(kd_eff);
        mb = derivative_mode ? satd(EW'(dt) - EW'(rate))
                             : satd(EW'(e) - EW'(previous_term));
      end
      S_Y: begin ma = sxf(output_gain); mb = total; end
      default: ;
    endcase
  end

  assign mctl.start = (state != S_IDLE) && (state != S_TOT) && (state != S_OUT)
                      && (state != S_WAIT) && !mul_wait;

  gpid_mul #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .ctl(mctl), .a(ma), .b(mb), .sts(msts), .p(mp)
  );

  // step order
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          state_next = (throttle > ThrottleWidth'(THROTTLE_THRESHOLD)) ? S_E : S_WAIT;
        end
      end
      S_E: if (msts.done) state_next = S_P;
      S_P: if (msts.done) state_next = S_I;
      S_I: if (msts.done) state_next = derivative_mode ? S_DS : S_D;
      S_DS: if (msts.done) state_next = S_D;
      S_D: if (msts.done) state_next = S_TOT;
      S_TOT: state_next = S_Y;
      S_Y: if (msts.done) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic signed [EW-1:0] tsum;
  logic signed [DW-1:0] tsat;
  logic signed [EW-1:0] olim, slim, wide_y;
  logic signed [DW-1:0] sum_clamped;
  assign tsum = EW'(pt) + EW'(it) + EW'(dt);
  assign tsat = satd(tsum);
  assign olim = EW'({1'b0, output_limit});
  assign slim = EW'({1'b0, sum_limit});
  assign wide_y = EW'(mp);

  always_comb begin
    sum_clamped = sum;
    if (sum_limit != NoClamp) begin
      if (EW'(sum) > slim) sum_clamped = slim[DW-1:0];
      else if (EW'(sum) < -slim) sum_clamped = DW'(-slim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      mul_wait <= 1'b0;
      error_sum <= '0;
      previous_term <= '0;
    end else begin
      state <= state_next;
      if (mctl.start) mul_wait <= 1'b1;
      else if (msts.done) mul_wait <= 1'b0;
      if (res_valid && !out_stall) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            sp <= sxf(setpoint);
            pv <= sxf(process_value);
            rate <= sxf(process_rate);
            if (throttle <= ThrottleWidth'(THROTTLE_THRESHOLD)) begin
              error_sum <= '0;
              previous_term <= '0;
              result <= '0;
              res_valid <= 1'b1;
            end
          end
        end
        S_E: if (msts.done) begin
          e <= satd(EW'(mp) - EW'(pv));
          sum <= satd(EW'(error_sum) + EW'(satd(EW'(mp) - EW'(pv))));
        end
        S_P: if (msts.done) pt <= mp;
        S_I: if (msts.done) it <= mp;
        S_DS: if (msts.done) dt <= mp;
        S_D: if (msts.done) begin
          dt <= mp;
          previous_term <= derivative_mode ? sp : e;
        end
        S_TOT: begin
          if (EW'(tsat) > olim) total <= olim[DW-1:0];
          else if (EW'(tsat) < -olim) total <= DW'(-olim);
          else total <= tsat;
        end
        S_Y: if (msts.done) begin
          if (wide_y > OMax) result <= OMax[FieldWidth-1:0];
          else if (wide_y < OMin) result <= OMin[FieldWidth-1:0];
          else result <= wide_y[FieldWidth-1:0];
        end
        S_OUT: begin
          error_sum <= sum_clamped;
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input open while busy");
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_OUT || $past(state) == S_IDLE))
    else $error("result from nowhere");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> (state == S_IDLE && !res_valid)) else $error("cfg open while busy");
`endif

endmodule
